>>> hdl/blinkc_pkg.sv
// shared types, constants and microprogram for the led blink controller
`default_nettype none
package blinkc_pkg;

	localparam int NUM_LEDS = 8;
	localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int PAD_W = (NUM_LEDS > 8) ? NUM_LEDS : 8;
	localparam int CNT_W = 32;

	localparam logic [1:0] FN_TICK = 2'd0;
	localparam logic [1:0] FN_SET = 2'd1;
	localparam logic [1:0] FN_BLINK = 2'd2;

	// step addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] S_DECODE = 4'd1;
	localparam logic [STEP_W-1:0] S_CMD = 4'd2;
	localparam logic [STEP_W-1:0] S_TLOAD = 4'd3;
	localparam logic [STEP_W-1:0] S_TDIV = 4'd4;
	localparam logic [STEP_W-1:0] S_TTEST = 4'd5;
	localparam logic [STEP_W-1:0] S_TNEXT = 4'd6;
	localparam logic [STEP_W-1:0] S_TEND = 4'd7;
	localparam logic [STEP_W-1:0] S_EMIT = 4'd8;

	// datapath actions
	localparam logic [2:0] A_NONE = 3'd0;
	localparam logic [2:0] A_CLEAR = 3'd1;
	localparam logic [2:0] A_CMD = 3'd2;
	localparam logic [2:0] A_DIVGO = 3'd3;
	localparam logic [2:0] A_TEST = 3'd4;
	localparam logic [2:0] A_LEDINC = 3'd5;
	localparam logic [2:0] A_TICKINC = 3'd6;
	localparam logic [2:0] A_EMIT = 3'd7;

	// jump conditions
	localparam logic [2:0] C_NEVER = 3'd0;
	localparam logic [2:0] C_IN_VALID = 3'd1;
	localparam logic [2:0] C_IS_TICK = 3'd2;
	localparam logic [2:0] C_RATE_ZERO = 3'd3;
	localparam logic [2:0] C_DIV_BUSY = 3'd4;
	localparam logic [2:0] C_LED_MORE = 3'd5;
	localparam logic [2:0] C_OUT_BUSY = 3'd6;

	typedef struct packed {
		logic [2:0] act;
		logic [2:0] cond;
		logic [STEP_W-1:0] jump;
		logic [STEP_W-1:0] next;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic is_tick;
		logic rate_zero;
		logic div_busy;
		logic led_more;
		logic out_busy;
	} status_t;

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		begin
			case (step)
				S_IDLE: w = '{A_NONE, C_IN_VALID, S_DECODE, S_IDLE};
				S_DECODE: w = '{A_CLEAR, C_IS_TICK, S_TLOAD, S_CMD};
				S_CMD: w = '{A_CMD, C_NEVER, S_EMIT, S_EMIT};
				S_TLOAD: w = '{A_DIVGO, C_RATE_ZERO, S_TNEXT, S_TDIV};
				S_TDIV: w = '{A_NONE, C_DIV_BUSY, S_TDIV, S_TTEST};
				S_TTEST: w = '{A_TEST, C_NEVER, S_TNEXT, S_TNEXT};
				S_TNEXT: w = '{A_LEDINC, C_LED_MORE, S_TLOAD, S_TEND};
				S_TEND: w = '{A_TICKINC, C_NEVER, S_EMIT, S_EMIT};
				S_EMIT: w = '{A_EMIT, C_OUT_BUSY, S_EMIT, S_IDLE};
				default: w = '{A_NONE, C_NEVER, S_IDLE, S_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage
`default_nettype wire

>>> hdl/blinkc_div.sv
// bit-serial 32-bit remainder unit, one quotient bit per cycle
`default_nettype none
module blinkc_div
	import blinkc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [CNT_W-1:0] dividend,
	input wire logic [CNT_W-1:0] divisor,
	output logic busy,
	output logic [CNT_W-1:0] rem
);

	localparam int ITER_W = $clog2(CNT_W);

	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] shift_q;
	logic [CNT_W-1:0] dvs_q;
	logic [ITER_W-1:0] iter_q;
	logic busy_q;
	logic [CNT_W:0] cand;
	logic [CNT_W:0] diff;

	assign cand = {rem_q, shift_q[CNT_W-1]};
	assign diff = cand - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= iter_q + 1'b1;
			if (iter_q == ITER_W'(CNT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			shift_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[CNT_W-2:0], 1'b0};
			if (!diff[CNT_W]) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= cand[CNT_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem = rem_q;

endmodule
`default_nettype wire

>>> hdl/blinkc_seq.sv
// microprogram step counter with conditional jumps over the control rom
`default_nettype none
module blinkc_seq
	import blinkc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire status_t stat,
	output uword_t ctl,
	output logic [STEP_W-1:0] step
);

	logic [STEP_W-1:0] upc_q;
	uword_t word;
	logic take;

	assign word = ucode(upc_q);

	always_comb begin
		case (word.cond)
			C_NEVER: take = 1'b0;
			C_IN_VALID: take = stat.in_valid;
			C_IS_TICK: take = stat.is_tick;
			C_RATE_ZERO: take = stat.rate_zero;
			C_DIV_BUSY: take = stat.div_busy;
			C_LED_MORE: take = stat.led_more;
			C_OUT_BUSY: take = stat.out_busy;
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= take ? word.jump : word.next;
		end
	end

	assign ctl = word;
	assign step = upc_q;

endmodule
`default_nettype wire

>>> hdl/multi_led_blink_controller.sv
// led blink controller top level: datapath, sequencer and remainder unit
`default_nettype none
// Takes one word at a time and returns one result word per input word. A set or
// blink command runs through the idle, decode, command and emit steps. A tick
// walks the LEDs one by one: an LED with rate 0 is skipped, any other LED waits
// on the shared bit-serial remainder unit, which resolves one bit of the 32-bit
// tick count per cycle, and is then tested for a toggle. A new word is taken
// only when the sequencer is back at its idle step; a finished result waits in
// the output register without holding off the next input word.
module multi_led_blink_controller
	import blinkc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [39:0] s_tdata, // led_index, level, blink_rate, zero pad
	input wire logic [1:0] s_tuser, // func
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata // pins, toggled
);

	logic [1:0] func_q;
	logic [2:0] idx_q;
	logic level_q;
	logic [CNT_W-1:0] brate_q;

	logic [NUM_LEDS-1:0] pin_q;
	logic [NUM_LEDS-1:0] flag_q;
	logic [NUM_LEDS-1:0] hit_q;
	logic [CNT_W-1:0] rate_q [NUM_LEDS];
	logic [CNT_W-1:0] tick_q;
	logic [LED_W-1:0] led_q;

	logic m_tvalid_q;
	logic [15:0] out_q;

	uword_t ctl;
	status_t stat;
	logic [STEP_W-1:0] step;
	logic div_busy;
	logic [CNT_W-1:0] div_rem;
	logic [CNT_W-1:0] cur_rate;
	logic idx_ok;
	logic [LED_W-1:0] widx;
	logic [PAD_W-1:0] pin_ext;
	logic [PAD_W-1:0] hit_ext;

	assign s_tready = (step == S_IDLE);
	assign cur_rate = rate_q[led_q];
	assign idx_ok = (32'(idx_q) < NUM_LEDS);
	assign widx = LED_W'(idx_q);
	assign pin_ext = PAD_W'(pin_q);
	assign hit_ext = PAD_W'(hit_q);

	assign stat.in_valid = s_tvalid;
	assign stat.is_tick = (func_q == FN_TICK);
	assign stat.rate_zero = (cur_rate == '0);
	assign stat.div_busy = div_busy;
	assign stat.led_more = (led_q != LED_W'(NUM_LEDS - 1));
	assign stat.out_busy = m_tvalid_q && !m_tready;

	blinkc_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.ctl(ctl),
		.step(step)
	);

	blinkc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(ctl.act == A_DIVGO && cur_rate != '0),
		.dividend(tick_q),
		.divisor(cur_rate),
		.busy(div_busy),
		.rem(div_rem)
	);

	// input word capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser;
			idx_q <= s_tdata[2:0];
			level_q <= s_tdata[3];
			brate_q <= s_tdata[35:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q <= '0;
			flag_q <= '0;
			hit_q <= '0;
			tick_q <= '0;
			led_q <= '0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				rate_q[i] <= '0;
			end
		end else begin
			case (ctl.act)
				A_CLEAR: begin
					hit_q <= '0;
					led_q <= '0;
				end
				A_CMD: begin
					if (idx_ok && func_q == FN_SET) begin
						pin_q[widx] <= level_q;
					end
					if (idx_ok && func_q == FN_BLINK) begin
						flag_q[widx] <= 1'b0;
						rate_q[widx] <= brate_q;
					end
				end
				A_TEST: begin
					if (div_rem == '0) begin
						flag_q[led_q] <= ~flag_q[led_q];
						pin_q[led_q] <= ~flag_q[led_q];
						hit_q[led_q] <= 1'b1;
					end
				end
				A_LEDINC: begin
					if (stat.led_more) begin
						led_q <= led_q + 1'b1;
					end
				end
				A_TICKINC: begin
					tick_q <= tick_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.act == A_EMIT && !stat.out_busy) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act == A_EMIT && !stat.out_busy) begin
			out_q <= {hit_ext[7:0], pin_ext[7:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_q;

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (step == S_DECODE))
		else $error("accepted word not decoded");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (step == S_TDIV))
		else $error("remainder unit busy outside its wait step");

	a_tick_once: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != $past(tick_q)) |-> ($past(step) == S_TEND))
		else $error("tick count moved outside end of tick");

endmodule
`default_nettype wire

>>> test/multi_led_blink_controller_tb.sv
// testbench for the led blink controller: directed and random command streams checked against a predictor
`timescale 1ns / 1ps

module multi_led_blink_controller_tb
	import blinkc_pkg::*;
();

	localparam logic [1:0] FN_SPARE = 2'd3;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_WORDS = 400;

	typedef struct packed {
		logic [7:0] toggled;
		logic [7:0] pins;
	} led_result_t;

	class blink_scoreboard;
		logic [7:0] pin_lv;
		logic [7:0] flags;
		logic [31:0] rate_tab [NUM_LEDS];
		logic [31:0] ticks;
		led_result_t pending [$];
		int errors;

		function new();
			pin_lv = '0;
			flags = '0;
			foreach (rate_tab[i]) rate_tab[i] = '0;
			ticks = '0;
			errors = 0;
		endfunction

		function void note_word(logic [1:0] fn, logic [39:0] data);
			logic [2:0] idx;
			logic lvl;
			logic [31:0] rate;
			logic [7:0] hit;
			led_result_t res;
			idx = data[2:0];
			lvl = data[3];
			rate = data[35:4];
			hit = '0;
			if (fn == FN_TICK) begin
				for (int i = 0; i < NUM_LEDS; i++) begin
					if (rate_tab[i] != 0 && ticks % rate_tab[i] == 0) begin
						flags[i] = ~flags[i];
						pin_lv[i] = flags[i];
						hit[i] = 1'b1;
					end
				end
				ticks = ticks + 1;
			end else if (fn == FN_SET) begin
				if (idx < NUM_LEDS) pin_lv[idx] = lvl;
			end else if (fn == FN_BLINK) begin
				if (idx < NUM_LEDS) begin
					flags[idx] = 1'b0;
					rate_tab[idx] = rate;
				end
			end
			res.pins = pin_lv;
			res.toggled = hit;
			pending.push_back(res);
		endfunction

		function void check_word(logic [15:0] data);
			led_result_t got;
			led_result_t want;
			got = data;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, data);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got.pins !== want.pins) begin
					$display("%0t: pins mismatch, expected %h, actual %h",
						$time, want.pins, got.pins);
					errors++;
				end
				if (got.toggled !== want.toggled) begin
					$display("%0t: toggled mismatch, expected %h, actual %h",
						$time, want.toggled, got.toggled);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata; // led_index, level, blink_rate, zero pad
	logic [1:0] s_tuser; // func
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata; // pins, toggled

	blink_scoreboard board;
	bit hold_req;
	bit quiet;
	int idle_cycles;

	multi_led_blink_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// monitors and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) board.note_word(s_tuser, s_tdata);
			if (m_tvalid && m_tready) board.check_word(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// result side
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic send_word(input logic [1:0] fn, input logic [2:0] idx, input logic lvl,
			input logic [31:0] rate);
		int gap;
		begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 4);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser <= fn;
			s_tdata <= {4'b0000, rate, lvl, idx};
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (board.pending.size() != 0) @(posedge clk);
		end
	endtask

	initial begin
		int sel;
		int pick;
		logic [31:0] rate;
		board = new();
		hold_req = 1'b0;
		quiet = 1'b0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= FN_TICK;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_word(FN_SPARE, 3'd7, 1'b1, 32'hFFFF_FFFF);
		send_word(FN_BLINK, 3'd6, 1'b0, 32'hFFFF_FFFF);
		send_word(FN_TICK, 3'd0, 1'b0, 32'h0);
		send_word(FN_SET, 3'd0, 1'b1, 32'h0);
		send_word(FN_SET, 3'd7, 1'b1, 32'h0);
		send_word(FN_SET, 3'd6, 1'b0, 32'h0);
		send_word(FN_BLINK, 3'd0, 1'b1, 32'd1);
		send_word(FN_BLINK, 3'd3, 1'b0, 32'd2);
		send_word(FN_BLINK, 3'd5, 1'b0, 32'd3);
		repeat (4) send_word(FN_TICK, 3'd7, 1'b1, 32'hFFFF_FFFF);
		send_word(FN_BLINK, 3'd0, 1'b0, 32'd0);
		send_word(FN_SET, 3'd3, 1'b1, 32'h0);
		send_word(FN_TICK, 3'd0, 1'b0, 32'h0);
		send_word(FN_BLINK, 3'd7, 1'b1, 32'h8000_0000);
		for (int i = 0; i < NUM_LEDS; i++) send_word(FN_BLINK, 3'(i), 1'b0, 32'd1);
		repeat (2) send_word(FN_TICK, 3'd0, 1'b0, 32'h0);
		wait_results_done();

		// random part
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 100) hold_req = 1'b1;
			if (n == 200) wait_results_done();
			if (n == 340) quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55) rate = $urandom_range(1, 6);
			else if (pick < 70) rate = $urandom_range(7, 64);
			else if (pick < 88) rate = $urandom;
			else rate = 32'd0;
			sel = $urandom_range(0, 99);
			if (sel < 45) send_word(FN_TICK, 3'($urandom), 1'($urandom), $urandom);
			else if (sel < 65) send_word(FN_SET, 3'($urandom), 1'($urandom), $urandom);
			else if (sel < 93) send_word(FN_BLINK, 3'($urandom), 1'($urandom), rate);
			else send_word(FN_SPARE, 3'($urandom), 1'($urandom), $urandom);
		end

		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/blinkc_pkg.sv
hdl/blinkc_div.sv
hdl/blinkc_seq.sv
hdl/multi_led_blink_controller.sv
test/multi_led_blink_controller_tb.sv
